[rtl/rrts_pkg.sv]
// Shared types and codes for the round-robin thread scheduler.
// No dependencies.
package rrts_pkg;

  localparam int THREADS_DEF = 16;
  localparam int TID_W = 4;

  localparam logic [2:0] ST_UNUSED     = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_RUNNING    = 3'd2;
  localparam logic [2:0] ST_BLOCKED    = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  localparam logic [2:0] K_SPAWN  = 3'd0;
  localparam logic [2:0] K_TERM   = 3'd1;
  localparam logic [2:0] K_BLOCK  = 3'd2;
  localparam logic [2:0] K_RESUME = 3'd3;
  localparam logic [2:0] K_SLEEP  = 3'd4;
  localparam logic [2:0] K_TICK   = 3'd5;
  localparam logic [2:0] K_QUERY  = 3'd6;

  localparam logic [2:0] S_OK      = 3'd0;
  localparam logic [2:0] S_BAD_ID  = 3'd1;
  localparam logic [2:0] S_NO_THR  = 3'd2;
  localparam logic [2:0] S_MAIN    = 3'd3;
  localparam logic [2:0] S_NO_SLOT = 3'd4;
  localparam logic [2:0] S_BAD_CNT = 3'd5;
  localparam logic [2:0] S_EXIT    = 3'd6;

  // Per-slot state carried by one cell.
  typedef struct packed {
    logic [2:0]  st;
    logic        hold;
    logic [31:0] runs;
    logic [31:0] wake;
  } slot_t;

endpackage

[rtl/rrts_cell.sv]
// One thread slot cell: holds the slot state and applies per-slot writes.
// Depends on rrts_pkg.
module rrts_cell import rrts_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  slot_t wdata,
  output slot_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.st   <= (IDX == 0) ? ST_RUNNING : ST_UNUSED;
      q.hold <= 1'b0;
      q.runs <= (IDX == 0) ? 32'd1 : 32'd0;
      q.wake <= 32'd0;
    end else if (wr) begin
      q <= wdata;
    end
  end

endmodule

[rtl/rrts_qcell.sv]
// One ready-queue position; shifts toward the head from its upper neighbor.
// Depends on rrts_pkg.
module rrts_qcell import rrts_pkg::*; #(
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  logic [TW-1:0] up,
  input  logic [TW-1:0] din,
  output logic [TW-1:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= din;
    end else if (shift) begin
      q <= up;
    end
  end

endmodule

[rtl/round_robin_thread_scheduler_unit.sv]
// Top level of the round-robin thread scheduler: sequencer, slot cells and
// ready-queue cells. Depends on rrts_pkg, rrts_cell, rrts_qcell.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: kind[2:0], thread_id[6:3], sleep_quanta[22:7]
//  m_axis  | out | tdata: status, new_thread_id, running_thread,
//          |     |        total_quanta, thread_quanta, switched
//
// A command with a reschedule goes from accept through decode, a wake scan of
// one slot per cycle, dispatch, the result beat and the idle state to the next
// accept. A spawn searches for a free slot, one slot a cycle; all other commands
// go from decode to the result beat. Reset makes slot 0 running and the other
// slots unused, clears queue count and running id and sets the quantum total
// to 1. One command is in work at a time; input is held off until the result
// beat is taken, and the result holds while m_axis_tready is low.
module round_robin_thread_scheduler_unit import rrts_pkg::*; #(
  parameter int THREADS = THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // kind, thread_id, sleep_quanta, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // status, new_thread_id, running_thread,
                                      // total_quanta, thread_quanta, switched, pad
);

  localparam int IW = $clog2(THREADS);
  localparam int CW = $clog2(THREADS + 1);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_EXEC  = 3'd1;
  localparam logic [2:0] P_SPAWN = 3'd2;
  localparam logic [2:0] P_SCAN  = 3'd3;
  localparam logic [2:0] P_DISP  = 3'd4;
  localparam logic [2:0] P_DONE  = 3'd5;

  logic [2:0]  phase;
  logic [2:0]  kind;
  logic [3:0]  tid;
  logic [15:0] nq;
  logic [2:0]  status;
  logic [3:0]  new_id;
  logic        sw;
  logic [31:0] tq;
  logic [IW-1:0] running_id;
  logic [31:0] qtotal;
  logic [CW-1:0] rcount;
  logic [IW-1:0] scan;     // slot walker for spawn search and wake scan

  slot_t       cell_q  [THREADS];
  slot_t       cell_d  [THREADS];
  logic        cell_wr [THREADS];
  logic [IW-1:0] fifo  [THREADS];
  logic [IW-1:0] fifo_d;
  logic        q_shift [THREADS];
  logic        q_load  [THREADS];
  logic        rm_found [THREADS];
  logic        rm_seen;

  logic        valid_id;
  logic [IW-1:0] tix;
  logic [IW-1:0] next_id;
  slot_t       tgt;
  logic [2:0]  status_next;
  logic        rm_en, push_en, push_ok, push_prev, pop_en, resched;
  logic [IW-1:0] push_id;
  logic [CW-1:0] cnt_after_pop;

  assign valid_id = ({28'd0, tid} < 32'(THREADS));
  assign tix = IW'(tid);
  assign next_id = fifo[0];
  assign tgt = cell_q[tix];
  assign cnt_after_pop = rcount - CW'(1);

  genvar g;
  generate
    for (g = 0; g < THREADS; g++) begin : g_slot
      rrts_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst(rst), .wr(cell_wr[g]), .wdata(cell_d[g]), .q(cell_q[g])
      );
      rrts_qcell #(.TW(IW)) u_q (
        .clk(clk), .shift(q_shift[g]), .load(q_load[g]),
        .up((g == THREADS - 1) ? fifo[g] : fifo[(g + 1) % THREADS]),
        .din(fifo_d), .q(fifo[g])
      );
    end
  endgenerate

  function automatic logic exists_f(input slot_t s);
    return s.st != ST_UNUSED && s.st != ST_TERMINATED;
  endfunction

  assign s_axis_tready = (phase == P_IDLE);
  assign m_axis_tvalid = (phase == P_DONE);
  assign m_axis_tdata = {4'd0, sw, tq, qtotal, 4'(running_id), new_id, status};

  // First queue position holding tid; it and every position above shift down.
  always_comb begin
    rm_seen = 1'b0;
    for (int i = 0; i < THREADS; i++) begin
      rm_seen = rm_seen | ((fifo[i] == tix) && (CW'(i) < rcount));
      rm_found[i] = rm_seen;
    end
  end

  // Slot writes and queue actions: at most one queue action a cycle, but dispatch may pop and push together.
  always_comb begin
    status_next = S_OK;
    rm_en = 1'b0; push_en = 1'b0; push_ok = 1'b0; push_prev = 1'b0;
    pop_en = 1'b0; resched = 1'b0;
    push_id = '0;
    fifo_d = '0;
    for (int i = 0; i < THREADS; i++) begin
      cell_wr[i] = 1'b0;
      cell_d[i]  = cell_q[i];
      q_shift[i] = 1'b0;
      q_load[i]  = 1'b0;
    end
    unique case (phase)
      P_EXEC: begin
        unique case (kind)
          K_SPAWN: status_next = S_NO_SLOT;
          K_TERM: begin
            if (!valid_id) status_next = S_BAD_ID;
            else if (!exists_f(tgt)) status_next = S_NO_THR;
            else if (tix == '0) status_next = S_EXIT;
            else begin
              rm_en = 1'b1;
              cell_wr[tix] = 1'b1;
              cell_d[tix].st = ST_TERMINATED;
              cell_d[tix].hold = 1'b0;
              resched = (tix == running_id);
            end
          end
          K_BLOCK: begin
            if (tid == 4'd0) status_next = S_MAIN;
            else if (!valid_id) status_next = S_BAD_ID;
            else if (!exists_f(tgt)) status_next = S_NO_THR;
            else begin
              cell_wr[tix] = 1'b1;
              cell_d[tix].hold = 1'b1;
              if (!tgt.hold && tgt.st == ST_READY) begin
                rm_en = 1'b1;
                cell_d[tix].st = ST_BLOCKED;
              end
              // a thread blocking itself leaves the processor
              if (tix == running_id) begin
                cell_d[tix].st = ST_BLOCKED;
                resched = 1'b1;
              end
            end
          end
          K_RESUME: begin
            if (!valid_id) status_next = S_BAD_ID;
            else if (!exists_f(tgt)) status_next = S_NO_THR;
            else if (tgt.hold) begin
              cell_wr[tix] = 1'b1;
              cell_d[tix].hold = 1'b0;
              if (tgt.st == ST_BLOCKED && (tgt.wake == 32'd0 || qtotal > tgt.wake)) begin
                cell_d[tix].st = ST_READY;
                cell_d[tix].wake = 32'd0;
                push_en = 1'b1;
                push_id = tix;
              end
            end
          end
          K_SLEEP: begin
            if (running_id == '0) status_next = S_MAIN;
            else if (nq == 16'd0) status_next = S_BAD_CNT;
            else begin
              cell_wr[running_id] = 1'b1;
              cell_d[running_id].wake = qtotal + 32'(nq) + 32'd1;
              cell_d[running_id].st = ST_BLOCKED;
              resched = 1'b1;
            end
          end
          K_TICK: resched = 1'b1;
          K_QUERY: begin
            if (!valid_id) status_next = S_BAD_ID;
            else if (!exists_f(tgt)) status_next = S_NO_THR;
          end
          default: ;
        endcase
      end
      P_SPAWN: begin
        if (!exists_f(cell_q[scan])) begin
          cell_wr[scan] = 1'b1;
          cell_d[scan].st = ST_READY;
          cell_d[scan].hold = 1'b0;
          cell_d[scan].runs = 32'd0;
          cell_d[scan].wake = 32'd0;
          push_en = 1'b1;
          push_id = scan;
        end
      end
      P_SCAN: begin
        if (cell_q[scan].st == ST_BLOCKED && cell_q[scan].wake != 32'd0 &&
            qtotal >= cell_q[scan].wake && !cell_q[scan].hold) begin
          cell_wr[scan] = 1'b1;
          cell_d[scan].st = ST_READY;
          cell_d[scan].wake = 32'd0;
          push_en = 1'b1;
          push_id = scan;
        end
      end
      P_DISP: begin
        if (rcount != '0) begin
          pop_en = 1'b1;
          if (cell_q[running_id].st == ST_RUNNING) begin
            cell_wr[running_id] = 1'b1;
            cell_d[running_id].st = ST_READY;
            if (!cell_q[running_id].hold) push_prev = 1'b1;
          end
          // the dispatched thread wins when it is also the previous one
          cell_wr[next_id] = 1'b1;
          cell_d[next_id] = cell_q[next_id];
          cell_d[next_id].st = ST_RUNNING;
          cell_d[next_id].runs = cell_q[next_id].runs + 32'd1;
        end
      end
      default: ;
    endcase
    if (rm_en) begin
      for (int i = 0; i < THREADS; i++) q_shift[i] = rm_found[i];
    end
    if (pop_en) begin
      for (int i = 0; i < THREADS; i++) q_shift[i] = 1'b1;
    end
    if (push_en && rcount < CW'(THREADS)) begin
      push_ok = 1'b1;
      fifo_d = push_id;
      q_load[rcount[IW-1:0]] = 1'b1;
    end
    if (push_prev) begin
      // head was popped this cycle, so the tail slot is rcount-1
      fifo_d = running_id;
      q_load[cnt_after_pop[IW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      running_id <= '0;
      qtotal <= 32'd1;
      rcount <= '0;
      scan <= '0;
      kind <= K_TICK;
      tid <= 4'd0;
      nq <= 16'd0;
      status <= S_OK;
      new_id <= 4'd0;
      sw <= 1'b0;
      tq <= 32'd0;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (s_axis_tvalid) begin
            kind <= s_axis_tdata[2:0];
            tid  <= s_axis_tdata[6:3];
            nq   <= s_axis_tdata[22:7];
            status <= S_OK; new_id <= 4'd0; sw <= 1'b0; tq <= 32'd0;
            phase <= P_EXEC;
          end
        end
        P_EXEC: begin
          status <= status_next;
          if (kind == K_QUERY && valid_id && exists_f(tgt)) tq <= tgt.runs;
          if (rm_en && rm_found[THREADS-1]) rcount <= rcount - CW'(1);
          else if (push_ok) rcount <= rcount + CW'(1);
          if (kind == K_SPAWN) begin
            scan <= IW'(1);
            phase <= P_SPAWN;
          end else if (resched) begin
            qtotal <= qtotal + 32'd1;
            scan <= '0;
            phase <= P_SCAN;
          end else phase <= P_DONE;
        end
        P_SPAWN: begin
          if (!exists_f(cell_q[scan])) begin
            status <= S_OK;
            new_id <= 4'(scan);
            if (push_ok) rcount <= rcount + CW'(1);
            phase <= P_DONE;
          end else if (scan == IW'(THREADS - 1)) phase <= P_DONE;
          else scan <= scan + IW'(1);
        end
        P_SCAN: begin
          if (push_ok) rcount <= rcount + CW'(1);
          if (scan == IW'(THREADS - 1)) phase <= P_DISP;
          else scan <= scan + IW'(1);
        end
        P_DISP: begin
          if (rcount != '0) begin
            running_id <= next_id;
            sw <= (next_id != running_id);
            if (!push_prev) rcount <= rcount - CW'(1);
          end
          phase <= P_DONE;
        end
        P_DONE: begin
          if (m_axis_tready) phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule
